@@ design/txc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the text console writer.
// Depends on nothing; every other file of the block imports it.
package txc_pkg;

	// Default screen geometry
	localparam int unsigned COLUMNS_DEF = 80;
	localparam int unsigned ROWS_DEF    = 25;

	// Field widths fixed by the interface
	localparam int unsigned CURSOR_W = 11;
	localparam int unsigned INDEX_W  = 11;
	localparam int unsigned CFG_W    = 4;

	// Character codes and blank cell contents
	localparam logic [7:0] CHAR_NL    = 8'd10;
	localparam logic [7:0] CHAR_CR    = 8'd13;
	localparam logic [7:0] BLANK_CHAR = 8'h20;
	localparam logic [7:0] BLANK_ATTR = 8'h0F;

	// Configuration register indexes
	localparam logic REG_FG = 1'b0;
	localparam logic REG_BG = 1'b1;

	typedef enum logic [1:0] {
		CMD_PUT   = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]         command;
		logic [7:0]         char_code;
		logic [INDEX_W-1:0] cell_index;
	} in_item_t;

	typedef struct packed {
		logic [CURSOR_W-1:0] cursor_cell;
		logic [7:0]          read_char;
		logic [7:0]          read_attr;
	} out_item_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_EXEC,
		S_READ,
		S_SCR_RD,
		S_SCR_WR,
		S_FILL,
		S_DONE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic latch;
		logic exec_put;
		logic home;
		logic sweep_zero;
		logic sweep_inc;
		logic wr_blank;
		logic wr_copy;
		logic rd_idx;
		logic rd_copy;
		logic emit;
		logic emit_read;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		cmd_t cmd;
		logic scroll;
		logic last_keep;
		logic last_cell;
	} ctl_sts_t;

endpackage

@@ design/txc_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine of the text console writer.
// Depends on txc_pkg; drives the datapath through ctl_cmd_t.
module txc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  txc_pkg::ctl_sts_t sts,
	output txc_pkg::ctl_cmd_t ctl,
	output logic              busy
);
	import txc_pkg::*;

	state_t state_q;
	state_t state_d;

	// Hold the state; reset starts with the blanking sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT: begin
				if (sts.last_cell) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) state_d = S_EXEC;
			end
			S_EXEC: begin
				case (sts.cmd)
					CMD_PUT:   state_d = sts.scroll ? S_SCR_RD : S_DONE;
					CMD_CLEAR: state_d = S_FILL;
					CMD_READ:  state_d = S_READ;
					default:   state_d = S_DONE;
				endcase
			end
			S_READ:   state_d = S_IDLE;
			S_SCR_RD: state_d = S_SCR_WR;
			S_SCR_WR: state_d = sts.last_keep ? S_FILL : S_SCR_RD;
			S_FILL: begin
				if (sts.last_cell) state_d = S_IDLE;
			end
			S_DONE:   state_d = S_IDLE;
			default:  state_d = S_INIT;
		endcase
	end

	// Commands to the datapath
	always_comb begin
		ctl  = '0;
		busy = (state_q != S_IDLE);
		case (state_q)
			S_INIT: begin
				ctl.wr_blank  = 1'b1;
				ctl.sweep_inc = 1'b1;
			end
			S_IDLE: begin
				ctl.latch = start;
			end
			S_EXEC: begin
				case (sts.cmd)
					CMD_PUT: begin
						ctl.exec_put   = 1'b1;
						ctl.sweep_zero = sts.scroll;
					end
					CMD_CLEAR: begin
						ctl.home       = 1'b1;
						ctl.sweep_zero = 1'b1;
					end
					CMD_READ: ctl.rd_idx = 1'b1;
					default:  ctl = '0;
				endcase
			end
			S_READ: begin
				ctl.emit      = 1'b1;
				ctl.emit_read = 1'b1;
			end
			S_SCR_RD: ctl.rd_copy = 1'b1;
			S_SCR_WR: begin
				ctl.wr_copy   = 1'b1;
				ctl.sweep_inc = 1'b1;
			end
			S_FILL: begin
				ctl.wr_blank  = 1'b1;
				ctl.sweep_inc = 1'b1;
				ctl.emit      = sts.last_cell;
			end
			S_DONE:  ctl.emit = 1'b1;
			default: ctl = '0;
		endcase
	end

endmodule

@@ design/txc_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the text console writer: screen memory, cursor, sweep counter,
// configuration registers and result register. Depends on txc_pkg.
module txc_datapath #(
	parameter int unsigned COLUMNS = txc_pkg::COLUMNS_DEF,
	parameter int unsigned ROWS    = txc_pkg::ROWS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  txc_pkg::ctl_cmd_t        ctl,
	output txc_pkg::ctl_sts_t        sts,
	input  txc_pkg::in_item_t        in_item,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [txc_pkg::CFG_W-1:0] cfg_data,
	output logic                     done,
	output txc_pkg::out_item_t       result
);
	import txc_pkg::*;

	localparam int unsigned CELLS = COLUMNS * ROWS;
	localparam int unsigned KEEP  = CELLS - COLUMNS;
	localparam int unsigned AW    = $clog2(CELLS);
	localparam int unsigned CW    = $clog2(CELLS + 1);
	localparam int unsigned COLW  = $clog2(COLUMNS);

	// Screen memory: attribute in the high byte, character in the low byte
	logic [15:0]        mem_q [CELLS];
	logic [15:0]        rd_data_q;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [15:0]        wr_data;
	logic [AW-1:0]      rd_addr;

	cmd_t               cmd_q;
	logic [7:0]         char_q;
	logic [INDEX_W-1:0] idx_q;
	logic [CFG_W-1:0]   fg_q;
	logic [CFG_W-1:0]   bg_q;
	logic [CW-1:0]      cur_q;
	logic [COLW-1:0]    col_q;
	logic [AW-1:0]      sweep_q;
	logic               done_q;
	out_item_t          result_q;

	logic [CW-1:0]      row_base;
	logic [CW-1:0]      cur_nxt;
	logic [COLW-1:0]    col_nxt;
	logic               ordinary;
	logic               scroll;
	logic               idx_ok;

	// Latch the command transaction
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q  <= cmd_t'(in_item.command);
			char_q <= in_item.char_code;
			idx_q  <= in_item.cell_index;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= CFG_W'(15);
			bg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FG:  fg_q <= cfg_data;
				REG_BG:  bg_q <= cfg_data;
				default: fg_q <= fg_q;
			endcase
		end
	end

	// Next cursor for a put: row start, next row start, or one step on
	always_comb begin
		row_base = cur_q - CW'(col_q);
		ordinary = (char_q != CHAR_NL) && (char_q != CHAR_CR);
		if (char_q == CHAR_NL) begin
			cur_nxt = row_base + CW'(COLUMNS);
			col_nxt = '0;
		end else if (char_q == CHAR_CR) begin
			cur_nxt = row_base;
			col_nxt = '0;
		end else begin
			cur_nxt = cur_q + CW'(1);
			col_nxt = (col_q == COLW'(COLUMNS - 1)) ? '0 : col_q + COLW'(1);
		end
		scroll = (cur_nxt >= CW'(CELLS));
	end

	// Cursor: a put past the last cell lands on the start of the bottom row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			col_q <= '0;
		end else if (ctl.home) begin
			cur_q <= '0;
			col_q <= '0;
		end else if (ctl.exec_put) begin
			cur_q <= scroll ? CW'(KEEP) : cur_nxt;
			col_q <= scroll ? '0 : col_nxt;
		end
	end

	// Sweep counter for clear, scroll and the reset blanking pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (ctl.sweep_zero) begin
			sweep_q <= '0;
		end else if (ctl.sweep_inc) begin
			sweep_q <= sweep_q + AW'(1);
		end
	end

	// Memory port selection
	always_comb begin
		wr_en   = (ctl.exec_put && ordinary) || ctl.wr_blank || ctl.wr_copy;
		wr_addr = ctl.exec_put ? AW'(cur_q) : sweep_q;
		if (ctl.wr_copy) begin
			wr_data = rd_data_q;
		end else if (ctl.wr_blank) begin
			wr_data = {BLANK_ATTR, BLANK_CHAR};
		end else begin
			wr_data = {bg_q, fg_q, char_q};
		end
		rd_addr = ctl.rd_copy ? AW'(sweep_q + AW'(COLUMNS)) : AW'(idx_q);
	end

	// Write one cell; read only for a cell read or a scroll copy
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		if (ctl.rd_idx || ctl.rd_copy) rd_data_q <= mem_q[rd_addr];
	end

	assign idx_ok = (32'(idx_q) < CELLS);

	// Result register, one strobe per command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			result_q.cursor_cell <= CURSOR_W'(cur_q);
			result_q.read_char   <= (ctl.emit_read && idx_ok) ? rd_data_q[7:0] : '0;
			result_q.read_attr   <= (ctl.emit_read && idx_ok) ? rd_data_q[15:8] : '0;
		end
	end

	// Status to the controller
	always_comb begin
		sts.cmd       = cmd_q;
		sts.scroll    = scroll;
		sts.last_keep = (sweep_q == AW'(KEEP - 1));
		sts.last_cell = (sweep_q == AW'(CELLS - 1));
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

@@ design/text_console_writer_unit.sv @@
`timescale 1ns / 1ps
// Put character or carriage return/newline: execute state, done state, then the registered result strobe.
// Read cell: execute state, read state, then the strobe. Clear: one memory write a cycle over every cell.
// Scroll: a read state and a write state per moved cell, then the bottom row is blanked.
// Next start is taken in the cycle of the strobe. After reset busy stays high
// while the sweep blanks the screen memory.
module text_console_writer_unit #(
	parameter int unsigned COLUMNS = txc_pkg::COLUMNS_DEF,
	parameter int unsigned ROWS    = txc_pkg::ROWS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  txc_pkg::in_item_t         in_item,
	output logic                      done,
	output txc_pkg::out_item_t        result,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [txc_pkg::CFG_W-1:0] cfg_data
);
	import txc_pkg::*;

	ctl_cmd_t ctl;
	ctl_sts_t sts;

	txc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	txc_datapath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.in_item   (in_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.done      (done),
		.result    (result)
	);

endmodule

@@ design/txc_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks of the text console writer, attached by bind.
// Depends on txc_pkg and the top level text_console_writer_unit.
module txc_checker #(
	parameter int unsigned COLUMNS = txc_pkg::COLUMNS_DEF,
	parameter int unsigned ROWS    = txc_pkg::ROWS_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input txc_pkg::out_item_t result
);
	import txc_pkg::*;

	localparam int unsigned CELLS = COLUMNS * ROWS;

	// An accepted transaction keeps the unit busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("unit not busy after accepting a transaction");

	// The result strobe is never high on consecutive cycles
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe on consecutive cycles");

	// A result follows a busy cycle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a transaction in work");

	// Reported cursor stays on the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(result.cursor_cell) < CELLS))
		else $error("cursor beyond the last cell");

	// Blanking pass runs right after reset
	a_reset_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> busy)
		else $error("unit idle before the blanking pass ends");

endmodule

bind text_console_writer_unit txc_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_txc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

@@ sim/text_console_writer_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of text_console_writer_unit: directed and random console commands.
// Depends on txc_pkg and the block itself; it keeps its own shadow of screen, cursor and colors.
module text_console_writer_unit_tb;
	import txc_pkg::*;

	localparam int unsigned COLS       = COLUMNS_DEF;
	localparam int unsigned LINES      = ROWS_DEF;
	localparam int unsigned CELLS      = COLS * LINES;
	localparam int unsigned SCROLL_CYC = 2 * (CELLS - COLS) + COLS + 2;
	localparam int unsigned CLEAR_CYC  = CELLS + 2;
	localparam int unsigned ITEM_GOAL  = 1450;

	typedef enum logic [1:0] {
		JOB_ITEM,
		JOB_CFG,
		JOB_DRAIN,
		JOB_PACE
	} job_kind_t;

	typedef struct {
		job_kind_t        kind;
		in_item_t         item;
		bit               near_cursor;
		logic             cfg_sel;
		logic [CFG_W-1:0] cfg_val;
		int unsigned      pace;
	} console_job_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             start     = 1'b0;
	logic             busy;
	in_item_t         in_item   = '0;
	logic             done;
	out_item_t        result;
	logic             cfg_we    = 1'b0;
	logic             cfg_index = 1'b0;
	logic [CFG_W-1:0] cfg_data  = '0;

	// Shadow of the console state
	logic [7:0]       shadow_char [CELLS];
	logic [7:0]       shadow_attr [CELLS];
	int unsigned      shadow_cursor;
	logic [3:0]       fg_color;
	logic [3:0]       bg_color;

	console_job_t     job_queue [$];
	out_item_t        due_results [$];
	bit               took;
	int unsigned      idle_pct;
	longint unsigned  cycle_budget;
	longint unsigned  cycle_limit = 64'd100_000_000;
	longint unsigned  cycle_count;
	int unsigned      item_total;
	int unsigned      mismatch_count;
	int unsigned      accepted_count;
	int unsigned      checked_count;
	int unsigned      put_count;
	int unsigned      read_count;
	int unsigned      clear_count;
	int unsigned      scroll_count;
	int unsigned      cfg_count;

	text_console_writer_unit #(
		.COLUMNS(COLS),
		.ROWS(LINES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.in_item(in_item),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Blank every cell and home the cursor
	function automatic void blank_screen();
		for (int unsigned k = 0; k < CELLS; k++) begin
			shadow_char[k] = BLANK_CHAR;
			shadow_attr[k] = BLANK_ATTR;
		end
		shadow_cursor = 0;
	endfunction

	// Apply one console command to the shadow state and return its result
	function automatic out_item_t console_step(in_item_t it);
		out_item_t r;
		r = '0;
		case (cmd_t'(it.command))
			CMD_PUT: begin
				if (it.char_code == CHAR_NL) begin
					shadow_cursor = (shadow_cursor / COLS + 1) * COLS;
				end else if (it.char_code == CHAR_CR) begin
					shadow_cursor = (shadow_cursor / COLS) * COLS;
				end else begin
					shadow_char[shadow_cursor] = it.char_code;
					shadow_attr[shadow_cursor] = {bg_color, fg_color};
					shadow_cursor++;
				end
				// Move every row up and blank the bottom one
				if (shadow_cursor >= CELLS) begin
					for (int unsigned k = 0; k < CELLS - COLS; k++) begin
						shadow_char[k] = shadow_char[k + COLS];
						shadow_attr[k] = shadow_attr[k + COLS];
					end
					for (int unsigned k = CELLS - COLS; k < CELLS; k++) begin
						shadow_char[k] = BLANK_CHAR;
						shadow_attr[k] = BLANK_ATTR;
					end
					shadow_cursor = CELLS - COLS;
					scroll_count++;
				end
			end
			CMD_CLEAR: begin
				blank_screen();
			end
			CMD_READ: begin
				if (it.cell_index < CELLS) begin
					r.read_char = shadow_char[it.cell_index];
					r.read_attr = shadow_attr[it.cell_index];
				end
			end
			default: begin
			end
		endcase
		r.cursor_cell = shadow_cursor[CURSOR_W-1:0];
		return r;
	endfunction

	function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
			mismatch_count++;
		end
	endfunction

	// Queue one command; near_cursor turns cell_index into an offset back from the cursor
	task automatic add_item(cmd_t c, logic [7:0] ch, logic [INDEX_W-1:0] idx, bit near_cursor);
		console_job_t j;
		j = '{kind: JOB_ITEM, item: '0, near_cursor: near_cursor, cfg_sel: 1'b0,
			cfg_val: '0, pace: 0};
		j.item.command    = c;
		j.item.char_code  = ch;
		j.item.cell_index = idx;
		job_queue.push_back(j);
		item_total++;
		if (c == CMD_CLEAR)
			cycle_budget += CLEAR_CYC + 20;
		else if (c == CMD_PUT && ch == CHAR_NL)
			cycle_budget += SCROLL_CYC + 20;
		else if (c == CMD_PUT && ch != CHAR_CR)
			cycle_budget += SCROLL_CYC / COLS + 20;
		else
			cycle_budget += 20;
	endtask

	// Let everything due arrive, then act
	task automatic add_cfg(logic sel, logic [CFG_W-1:0] val);
		job_queue.push_back('{kind: JOB_DRAIN, item: '0, near_cursor: 1'b0, cfg_sel: 1'b0,
			cfg_val: '0, pace: 0});
		job_queue.push_back('{kind: JOB_CFG, item: '0, near_cursor: 1'b0, cfg_sel: sel,
			cfg_val: val, pace: 0});
		cycle_budget += 20;
	endtask

	task automatic add_pace(int unsigned pct);
		job_queue.push_back('{kind: JOB_DRAIN, item: '0, near_cursor: 1'b0, cfg_sel: 1'b0,
			cfg_val: '0, pace: 0});
		job_queue.push_back('{kind: JOB_PACE, item: '0, near_cursor: 1'b0, cfg_sel: 1'b0,
			cfg_val: '0, pace: pct});
		cycle_budget += 20;
	endtask

	// Drive commands and register writes from the job queue
	always @(negedge clk) begin : drive_console
		logic             nxt_start;
		in_item_t         nxt_item;
		logic             nxt_we;
		logic             nxt_sel;
		logic [CFG_W-1:0] nxt_data;
		console_job_t     j;
		nxt_start = start;
		nxt_item  = in_item;
		nxt_we    = 1'b0;
		nxt_sel   = cfg_index;
		nxt_data  = cfg_data;
		if (took) begin
			nxt_start = 1'b0;
			took      = 1'b0;
		end
		if (arst_n && !nxt_start && job_queue.size() != 0) begin
			j = job_queue[0];
			case (j.kind)
				JOB_ITEM: begin
					if ($urandom_range(99) >= idle_pct) begin
						nxt_item = j.item;
						if (j.near_cursor)
							nxt_item.cell_index = shadow_cursor[INDEX_W-1:0] - j.item.cell_index;
						nxt_start = 1'b1;
						void'(job_queue.pop_front());
					end
				end
				JOB_CFG: begin
					if (!busy && due_results.size() == 0) begin
						nxt_we   = 1'b1;
						nxt_sel  = j.cfg_sel;
						nxt_data = j.cfg_val;
						void'(job_queue.pop_front());
					end
				end
				JOB_DRAIN: begin
					if (due_results.size() == 0)
						void'(job_queue.pop_front());
				end
				default: begin
					idle_pct = j.pace;
					void'(job_queue.pop_front());
				end
			endcase
		end
		start     <= nxt_start;
		in_item   <= nxt_item;
		cfg_we    <= nxt_we;
		cfg_index <= nxt_sel;
		cfg_data  <= nxt_data;
	end

	// Check results, then record accepted transactions and register writes
	always @(posedge clk) begin : watch_console
		out_item_t want;
		cycle_count++;
		if (cycle_count > cycle_limit) begin
			$display("%0t: run did not finish within %0d cycles", $time, cycle_limit);
			$display("== FAIL ==");
			$finish;
		end else if (arst_n) begin
			if (done) begin
				if (due_results.size() == 0) begin
					$display("%0t: result with none due, expected nothing, got %0h", $time, result);
					mismatch_count++;
				end else begin
					want = due_results.pop_front();
					check_field("cursor_cell", 16'(want.cursor_cell), 16'(result.cursor_cell));
					check_field("read_char", 16'(want.read_char), 16'(result.read_char));
					check_field("read_attr", 16'(want.read_attr), 16'(result.read_attr));
					checked_count++;
				end
			end
			if (start && !busy) begin
				due_results.push_back(console_step(in_item));
				took = 1'b1;
				accepted_count++;
				case (cmd_t'(in_item.command))
					CMD_PUT:   put_count++;
					CMD_READ:  read_count++;
					CMD_CLEAR: clear_count++;
					default: begin
					end
				endcase
			end
			if (cfg_we) begin
				if (cfg_index == REG_FG)
					fg_color = cfg_data;
				else
					bg_color = cfg_data;
				cfg_count++;
			end
		end
	end

	initial begin : stimulus
		int unsigned pick;
		int unsigned len;
		int unsigned r;
		int unsigned phase;
		int unsigned pace_steps [4];
		logic [3:0]  val;
		pace_steps = '{0, 46, 0, 15};
		phase      = 0;
		blank_screen();
		fg_color   = 4'hF;
		bg_color   = 4'h0;
		idle_pct   = 0;

		// Directed: reset contents, range edges, unused command, control bytes, colors and a clear
		add_item(CMD_READ, 8'h00, 11'd0, 1'b0);
		add_item(CMD_READ, 8'hFF, 11'(CELLS - 1), 1'b0);
		add_item(CMD_READ, 8'h00, 11'(CELLS), 1'b0);
		add_item(CMD_READ, 8'h00, 11'h7FF, 1'b0);
		add_item(CMD_NONE, 8'hFF, 11'h7FF, 1'b0);
		add_item(CMD_PUT, 8'h00, 11'h7FF, 1'b0);
		add_item(CMD_PUT, 8'hFF, 11'd0, 1'b0);
		add_item(CMD_PUT, CHAR_NL, 11'd0, 1'b0);
		add_item(CMD_PUT, 8'h41, 11'd0, 1'b0);
		add_item(CMD_PUT, CHAR_CR, 11'd0, 1'b0);
		add_item(CMD_READ, 8'h00, 11'd0, 1'b0);
		add_item(CMD_READ, 8'h00, 11'd1, 1'b0);
		add_item(CMD_READ, 8'h00, 11'd80, 1'b0);
		add_cfg(REG_FG, 4'h0);
		add_cfg(REG_BG, 4'hF);
		add_item(CMD_PUT, 8'h7F, 11'd0, 1'b0);
		add_item(CMD_READ, 8'h00, 11'd80, 1'b0);
		add_item(CMD_CLEAR, 8'h00, 11'd0, 1'b0);
		add_item(CMD_READ, 8'h00, 11'd80, 1'b0);
		add_item(CMD_PUT, 8'h5A, 11'd0, 1'b0);
		add_item(CMD_READ, 8'h00, 11'd0, 1'b0);
		add_cfg(REG_FG, 4'hF);
		add_cfg(REG_BG, 4'h0);

		// Random: text lines, read bursts, noise, clears, color and pace changes
		while (item_total < ITEM_GOAL) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				r = $urandom_range(99);
				if (r < 80)
					len = $urandom_range(20);
				else if (r < 95)
					len = $urandom_range(79, 21);
				else
					len = $urandom_range(170, 80);
				for (int unsigned k = 0; k < len; k++)
					add_item(CMD_PUT, 8'($urandom_range(255)), 11'($urandom), 1'b0);
				r = $urandom_range(99);
				if (r < 70)
					add_item(CMD_PUT, CHAR_NL, 11'($urandom), 1'b0);
				else if (r < 85)
					add_item(CMD_PUT, CHAR_CR, 11'($urandom), 1'b0);
			end else if (pick < 80) begin
				len = $urandom_range(6, 1);
				for (int unsigned k = 0; k < len; k++) begin
					if ($urandom_range(99) < 70)
						add_item(CMD_READ, 8'($urandom), 11'($urandom_range(120)), 1'b1);
					else
						add_item(CMD_READ, 8'($urandom), 11'($urandom), 1'b0);
				end
			end else if (pick < 85) begin
				if ($urandom_range(1) == 0)
					add_item(CMD_NONE, 8'($urandom), 11'($urandom), 1'b0);
				else
					add_item(CMD_READ, 8'($urandom), 11'($urandom_range(2047, CELLS)), 1'b0);
			end else if (pick < 87) begin
				add_item(CMD_CLEAR, 8'($urandom), 11'($urandom), 1'b0);
			end else if (pick < 92) begin
				for (int unsigned k = 0; k < 2; k++) begin
					r = $urandom_range(99);
					if (r < 15)
						val = 4'h0;
					else if (r < 30)
						val = 4'hF;
					else
						val = 4'($urandom_range(15));
					add_cfg((k == 0) ? REG_FG : REG_BG, val);
				end
			end else begin
				phase++;
				add_pace(pace_steps[phase % 4]);
			end
		end
		cycle_limit = 3 * (cycle_budget + CELLS + 1000);

		// Hold reset, then release it away from the rising edge
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait out the queue and the results still due, then let the clock run on before the summary
		while (job_queue.size() != 0 || start || due_results.size() != 0)
			@(posedge clk);
		repeat (SCROLL_CYC + 20) @(posedge clk);

		$display("Ran %0d commands: %0d puts, %0d reads, %0d clears, %0d scrolls, %0d color writes",
			accepted_count, put_count, read_count, clear_count, scroll_count, cfg_count);
		$display("Checked %0d results, %0d mismatches", checked_count, mismatch_count);
		if (mismatch_count == 0 && due_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ text_console_writer_unit.f @@
design/txc_pkg.sv
design/txc_ctrl.sv
design/txc_datapath.sv
design/text_console_writer_unit.sv
design/txc_checker.sv
sim/text_console_writer_unit_tb.sv
